[hdl/chrgb_pkg.sv]
// Shared constants, types and helper functions of the count-to-color converter.
package chrgb_pkg;

  // Fraction format: unsigned Q0.FRAC_BITS, one = 2**FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int COUNT_W   = 10;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int BYTE_W    = 8;
  localparam int HUE_W     = FRAC_BITS + 1;
  localparam int H6_W      = FRAC_BITS + 3;
  localparam int SEXT_W    = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = 1'd1;

  // Register reset values (Q0.16)
  localparam logic [CFG_W-1:0] SAT_RESET = 16'd64880;
  localparam logic [CFG_W-1:0] LIT_RESET = 16'd26214;

  // Count saturation limits and band starts
  localparam logic [COUNT_W-1:0] COUNT_MIN   = 10'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 10'd1000;
  localparam logic [COUNT_W-1:0] BAND2_START = 10'd31;
  localparam logic [COUNT_W-1:0] BAND3_START = 10'd61;
  localparam logic [COUNT_W-1:0] WIDE_START  = 10'd91;

  // Reciprocals for the divide by 29 and by 999, rounded up, scaled by 2**(FRAC+20)
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = FRAC_BITS + RECIP_SHIFT - 4;
  localparam int PROD_W      = COUNT_W + RECIP_W;
  localparam logic [63:0] RECIP_29_FULL =
    ((64'd1 << (FRAC_BITS + RECIP_SHIFT)) + 64'd28) / 64'd29;
  localparam logic [63:0] RECIP_999_FULL =
    ((64'd1 << (FRAC_BITS + RECIP_SHIFT)) + 64'd998) / 64'd999;
  localparam logic [RECIP_W-1:0] RECIP_29  = RECIP_29_FULL[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] RECIP_999 = RECIP_999_FULL[RECIP_W-1:0];

  // Fraction value of one
  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Sextant codes
  localparam logic [SEXT_W-1:0] SEXT_0    = 3'd0;
  localparam logic [SEXT_W-1:0] SEXT_1    = 3'd1;
  localparam logic [SEXT_W-1:0] SEXT_2    = 3'd2;
  localparam logic [SEXT_W-1:0] SEXT_3    = 3'd3;
  localparam logic [SEXT_W-1:0] SEXT_4    = 3'd4;
  localparam logic [SEXT_W-1:0] SEXT_WRAP = 3'd6;

  // Hue stage result handed to the color mixer
  typedef struct packed {
    logic                 valid;
    logic [SEXT_W-1:0]    sextant;
    logic [FRAC_BITS-1:0] fract;
  } hue_t;

  // Brightest and darkest channel levels from saturation and lightness
  typedef struct packed {
    logic [FRAC_BITS:0] v;
    logic [FRAC_BITS:0] m;
  } level_t;

  // Rescale a Q0.16 register into the working fraction format
  function automatic logic [FRAC_BITS-1:0] to_frac(input logic [CFG_W-1:0] r);
    logic [FRAC_BITS+CFG_W-1:0] wide;
    wide = {r, {FRAC_BITS{1'b0}}};
    return wide[FRAC_BITS+CFG_W-1:CFG_W];
  endfunction

  // Truncate a fraction in 0..one to a byte of fraction times 255
  function automatic logic [BYTE_W-1:0] to_byte(input logic [FRAC_BITS:0] x);
    logic [FRAC_BITS+8:0] t;
    t = {x, 8'd0} - (FRAC_BITS + 9)'(x);
    return t[FRAC_BITS+7:FRAC_BITS];
  endfunction

endpackage

[hdl/chrgb_hue.sv]
// Hue pipeline: count saturation, band split, divide by reciprocal, sextant split.
module chrgb_hue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic [chrgb_pkg::COUNT_W-1:0] hit_count,
  output chrgb_pkg::hue_t               hue_out
);
  import chrgb_pkg::*;

  logic [COUNT_W-1:0]   count_sat;
  logic [COUNT_W-1:0]   num_next;
  logic                 wide_next;
  logic                 s1_valid;
  logic [COUNT_W-1:0]   s1_num;
  logic                 s1_wide;
  logic [RECIP_W-1:0]   recip;
  logic [PROD_W-1:0]    prod;
  logic                 s2_valid;
  logic [HUE_W-1:0]     s2_hue;
  logic [H6_W-1:0]      h6;
  logic [SEXT_W-1:0]    sext_next;
  logic [FRAC_BITS-1:0] fract_next;
  logic                 s3_valid;
  logic [SEXT_W-1:0]    s3_sextant;
  logic [FRAC_BITS-1:0] s3_fract;

  // Clamp the count and pick the band numerator
  always_comb begin
    count_sat = hit_count;
    if (hit_count < COUNT_MIN) begin
      count_sat = COUNT_MIN;
    end else if (hit_count > COUNT_MAX) begin
      count_sat = COUNT_MAX;
    end
    priority if (count_sat < BAND2_START) begin
      num_next  = count_sat - COUNT_MIN;
      wide_next = 1'b0;
    end else if (count_sat < BAND3_START) begin
      num_next  = count_sat - BAND2_START;
      wide_next = 1'b0;
    end else if (count_sat < WIDE_START) begin
      num_next  = count_sat - BAND3_START;
      wide_next = 1'b0;
    end else begin
      num_next  = count_sat - COUNT_MIN;
      wide_next = 1'b1;
    end
  end

  // Divide by the band length through a reciprocal multiply
  assign recip = s1_wide ? RECIP_999 : RECIP_29;
  assign prod  = PROD_W'(s1_num) * PROD_W'(recip);

  // Scale hue by six and split into sextant and fraction; a full hue wraps
  always_comb begin
    h6         = (H6_W'(s2_hue) << 2) + (H6_W'(s2_hue) << 1);
    sext_next  = h6[H6_W-1 -: SEXT_W];
    fract_next = h6[FRAC_BITS-1:0];
    if (sext_next >= SEXT_WRAP) begin
      sext_next  = SEXT_0;
      fract_next = '0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_num     <= num_next;
      s1_wide    <= wide_next;
      s2_hue     <= prod[RECIP_SHIFT +: HUE_W];
      s3_sextant <= sext_next;
      s3_fract   <= fract_next;
    end
  end

  always_comb begin
    hue_out.valid   = s3_valid;
    hue_out.sextant = s3_sextant;
    hue_out.fract   = s3_fract;
  end

endmodule

[hdl/chrgb_level.sv]
// Configuration registers and the brightest/darkest level computation.
module chrgb_level (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [chrgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chrgb_pkg::CFG_W-1:0]     cfg_data,
  output chrgb_pkg::level_t               level
);
  import chrgb_pkg::*;

  logic [CFG_W-1:0]       saturation;
  logic [CFG_W-1:0]       lightness;
  logic [FRAC_BITS-1:0]   s_frac;
  logic [FRAC_BITS-1:0]   l_frac;
  logic [2*FRAC_BITS-1:0] ls_prod;
  logic [FRAC_BITS-1:0]   ls;
  logic [FRAC_BITS+1:0]   two_l;
  logic [FRAC_BITS+1:0]   v_raw;
  logic [FRAC_BITS+1:0]   v_sat;
  logic [FRAC_BITS+1:0]   m_raw;
  logic [FRAC_BITS:0]     v_next;
  logic [FRAC_BITS:0]     m_next;
  logic [FRAC_BITS:0]     v_q;
  logic [FRAC_BITS:0]     m_q;

  // Hold register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= SAT_RESET;
      lightness  <= LIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SATURATION: saturation <= cfg_data;
        REG_LIGHTNESS:  lightness  <= cfg_data;
      endcase
    end
  end

  assign s_frac  = to_frac(saturation);
  assign l_frac  = to_frac(lightness);
  assign ls_prod = (2*FRAC_BITS)'(l_frac) * (2*FRAC_BITS)'(s_frac);

  // Brightest level, then darkest level, both clamped
  always_comb begin
    two_l = {1'b0, l_frac, 1'b0};
    if (two_l <= (FRAC_BITS + 2)'(FRAC_ONE)) begin
      v_raw = (FRAC_BITS + 2)'(l_frac) + (FRAC_BITS + 2)'(ls);
    end else begin
      v_raw = (FRAC_BITS + 2)'(l_frac) + (FRAC_BITS + 2)'(s_frac) - (FRAC_BITS + 2)'(ls);
    end
    v_sat = v_raw;
    if (v_raw > (FRAC_BITS + 2)'(FRAC_ONE)) begin
      v_sat = (FRAC_BITS + 2)'(FRAC_ONE);
    end
    m_raw = (two_l >= v_sat) ? (two_l - v_sat) : '0;
    if (m_raw > v_sat) begin
      m_raw = v_sat;
    end
    v_next = v_sat[FRAC_BITS:0];
    m_next = m_raw[FRAC_BITS:0];
  end

  // Register product, then levels
  always_ff @(posedge clk) begin
    ls  <= ls_prod[2*FRAC_BITS-1:FRAC_BITS];
    v_q <= v_next;
    m_q <= m_next;
  end

  always_comb begin
    level.v = v_q;
    level.m = m_q;
  end

endmodule

[hdl/chrgb_mix.sv]
// Color mixer: sextant offset multiply, channel select and byte conversion.
module chrgb_mix (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  chrgb_pkg::hue_t              hue_in,
  input  chrgb_pkg::level_t            level,
  output logic                         out_valid,
  output logic [chrgb_pkg::BYTE_W-1:0] red,
  output logic [chrgb_pkg::BYTE_W-1:0] green,
  output logic [chrgb_pkg::BYTE_W-1:0] blue
);
  import chrgb_pkg::*;

  logic [FRAC_BITS:0]     diff;
  logic [2*FRAC_BITS:0]   vsf_prod;
  logic                   s4_valid;
  logic [SEXT_W-1:0]      s4_sextant;
  logic [FRAC_BITS:0]     s4_vsf;
  logic [FRAC_BITS:0]     mid1;
  logic [FRAC_BITS:0]     mid2;
  logic [FRAC_BITS:0]     r_frac;
  logic [FRAC_BITS:0]     g_frac;
  logic [FRAC_BITS:0]     b_frac;

  // Scale the level span by the sextant fraction
  assign diff     = level.v - level.m;
  assign vsf_prod = (2*FRAC_BITS + 1)'(diff) * (2*FRAC_BITS + 1)'(hue_in.fract);

  // Rising and falling channel values
  assign mid1 = level.m + s4_vsf;
  assign mid2 = level.v - s4_vsf;

  // Route levels to channels by sextant
  always_comb begin
    unique case (s4_sextant)
      SEXT_0: begin
        r_frac = level.v; g_frac = mid1;    b_frac = level.m;
      end
      SEXT_1: begin
        r_frac = mid2;    g_frac = level.v; b_frac = level.m;
      end
      SEXT_2: begin
        r_frac = level.m; g_frac = level.v; b_frac = mid1;
      end
      SEXT_3: begin
        r_frac = level.m; g_frac = mid2;    b_frac = level.v;
      end
      SEXT_4: begin
        r_frac = mid1;    g_frac = level.m; b_frac = level.v;
      end
      default: begin
        r_frac = level.v; g_frac = level.m; b_frac = mid2;
      end
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s4_valid  <= hue_in.valid;
      out_valid <= s4_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s4_sextant <= hue_in.sextant;
      s4_vsf     <= vsf_prod[FRAC_BITS +: FRAC_BITS + 1];
      red        <= to_byte(r_frac);
      green      <= to_byte(g_frac);
      blue       <= to_byte(b_frac);
    end
  end

endmodule

[hdl/count_to_hsl_rgb_color_core.sv]
// Top level of the count-to-color converter: hue pipeline, level unit, mixer.
//
//   channel   direction  handshake              payload
//   request   in         in_valid / in_stall    hit_count[9:0]
//   result    out        out_valid / out_stall  red[7:0], green[7:0], blue[7:0]
//   config    in         cfg_write              cfg_index[0], cfg_data[15:0]
//
// One request per cycle while no result is held by out_stall; five register stages
// (clamp, reciprocal multiply, sextant split, span multiply, channel select) lie
// between a taken request and its result; the first is loaded at the taking edge.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline and in_stall follows out_stall
// while a result is held, so nothing is dropped or repeated.
// A register write reaches the level outputs through the product and level registers.
module count_to_hsl_rgb_color_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [chrgb_pkg::COUNT_W-1:0]   hit_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [chrgb_pkg::BYTE_W-1:0]    red,
  output logic [chrgb_pkg::BYTE_W-1:0]    green,
  output logic [chrgb_pkg::BYTE_W-1:0]    blue,
  input  logic                            cfg_write,
  input  logic [chrgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chrgb_pkg::CFG_W-1:0]     cfg_data
);
  import chrgb_pkg::*;

  logic   advance;
  hue_t   hue;
  level_t level;

  // Freeze the pipeline while a result is held
  assign in_stall = out_valid & out_stall;
  assign advance  = ~in_stall;

  chrgb_hue u_hue (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (in_valid),
    .hit_count (hit_count),
    .hue_out   (hue)
  );

  chrgb_level u_level (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .level     (level)
  );

  chrgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .hue_in    (hue),
    .level     (level),
    .out_valid (out_valid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // Zero lightness gives black
  a_black_on_zero_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (level.v == '0) |-> (red == '0) && (green == '0) && (blue == '0))
    else $error("nonzero color with zero level");

  // Some channel carries the brightest level
  a_peak_present: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == to_byte(level.v)) || (green == to_byte(level.v))
                  || (blue == to_byte(level.v)))
    else $error("no channel at the brightest level");

  // Some channel carries the darkest level
  a_floor_present: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == to_byte(level.m)) || (green == to_byte(level.m))
                  || (blue == to_byte(level.m)))
    else $error("no channel at the darkest level");

endmodule
